FILE: rtl/bhm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and helpers for the bucketed hash map.
package bhm_pkg;

   localparam int KEY_W          = 63;
   localparam int VAL_W          = 32;
   localparam int ENT_W          = KEY_W + VAL_W;
   localparam int DEF_NUM_BUCKETS = 64;
   localparam int DEF_WAYS       = 4;
   // key bits folded into the remainder per cycle
   localparam int MOD_DIG        = 4;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // ceil(log2(n)), never below one bit
   function automatic int clog2_min1(input int n);
      int w;
      w = $clog2(n);
      return (w < 1) ? 1 : w;
   endfunction

endpackage

FILE: rtl/bucketed_hash_map.sv
`timescale 1ns / 1ps
// Top level of the bucketed hash map: sequencer, key comparator and stores.
// Flow: the 16-step key reduction and a fill-count read; an insert then appends,
//   a lookup or remove scans the bucket, a remove hit moves entries down, and
//   the result goes out. Throughput: one request at a time, the next taken only
//   once the result has gone to the output register.
// Reset (synchronous, active high) starts a clearing pass over all the fill
//   counts, during which req_stall stays high.
module bucketed_hash_map
   import bhm_pkg::*;
#(
   parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
   parameter int WAYS        = DEF_WAYS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_found,
   output logic [VAL_W-1:0] rsp_result_value
);

   localparam int BKT_W     = clog2_min1(NUM_BUCKETS);
   localparam int ENT_DEPTH = NUM_BUCKETS * WAYS;
   localparam int EA_W      = clog2_min1(ENT_DEPTH);
   // fill counts run 0..WAYS; positions 0..WAYS-1
   localparam int FILL_W    = clog2_min1(WAYS + 1);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b00_0000_0001,
      S_IDLE     = 10'b00_0000_0010,
      S_MOD      = 10'b00_0000_0100,
      S_FILL_RD  = 10'b00_0000_1000,
      S_FILL_GET = 10'b00_0001_0000,
      S_SCAN_RD  = 10'b00_0010_0000,
      S_SCAN_CMP = 10'b00_0100_0000,
      S_SHIFT_RD = 10'b00_1000_0000,
      S_SHIFT_WR = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // request held for the whole operation
   logic [1:0]       type_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;

   logic [EA_W-1:0]   base_ff, base_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] pos_ff, pos_in;
   logic [BKT_W-1:0]  clr_cnt_ff, clr_cnt_in;

   // result waiting for the output register
   logic [1:0]       res_status_ff, res_status_in;
   logic             res_found_ff, res_found_in;
   logic [VAL_W-1:0] res_value_ff, res_value_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic             rsp_found_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   logic             req_beat;
   logic             out_free;
   logic             mod_done;
   logic [BKT_W-1:0] bucket;

   // entry store: {key, value} per slot, bucket b owns slots b*WAYS .. b*WAYS+WAYS-1
   logic             ent_we;
   logic [EA_W-1:0]  ent_waddr, ent_raddr;
   logic [ENT_W-1:0] ent_wdata, ent_rdata;
   logic [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0] rd_value;
   logic             key_hit;

   // fill counts, one per bucket
   logic              fill_we;
   logic [BKT_W-1:0]  fill_waddr;
   logic [FILL_W-1:0] fill_wdata, fill_rdata;

   assign req_beat = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rd_key   = ent_rdata[ENT_W-1:VAL_W];
   assign rd_value = ent_rdata[VAL_W-1:0];
   // the one shared comparator, used once per scanned entry
   assign key_hit  = (rd_key == key_ff);

   bhm_mod #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (req_beat),
      .key    (req_key),
      .done   (mod_done),
      .bucket (bucket)
   );

   bhm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENT_DEPTH)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   bhm_ram #(
      .WIDTH (FILL_W),
      .DEPTH (NUM_BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (bucket),
      .rd_data (fill_rdata)
   );

   // Sequencer. Within a bucket the newest entry sits at the highest slot, so
   // an insert appends at slot fill and a scan runs downwards from fill-1. A
   // remove moves the newer entries above the hit down by one, which keeps
   // the age order intact.
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      clr_cnt_in    = clr_cnt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_value_in  = res_value_ff;
      ent_we        = 1'b0;
      ent_waddr     = EA_W'(base_ff + EA_W'(pos_ff));
      ent_wdata     = ent_rdata;
      ent_raddr     = EA_W'(base_ff + EA_W'(pos_ff));
      fill_we       = 1'b0;
      fill_waddr    = bucket;
      fill_wdata    = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_cnt_ff;
            clr_cnt_in = BKT_W'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               base_in  = EA_W'(EA_W'(bucket) * EA_W'(WAYS));
               state_in = S_FILL_RD;
            end
         end
         S_FILL_RD: begin
            // fill RAM reads the bucket this cycle
            state_in = S_FILL_GET;
         end
         S_FILL_GET: begin
            fill_in       = fill_rdata;
            pos_in        = FILL_W'(fill_rdata - 1'b1);
            res_status_in = STATUS_MISS;
            res_found_in  = 1'b0;
            res_value_in  = '0;
            state_in      = S_DONE;
            case (type_ff)
               REQ_INSERT: begin
                  if (fill_rdata == FILL_W'(WAYS)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     ent_we        = 1'b1;
                     ent_waddr     = EA_W'(base_ff + EA_W'(fill_rdata));
                     ent_wdata     = {key_ff, value_ff};
                     fill_we       = 1'b1;
                     fill_wdata    = FILL_W'(fill_rdata + 1'b1);
                     res_status_in = STATUS_OK;
                  end
               end
               REQ_LOOKUP, REQ_REMOVE: begin
                  if (fill_rdata != '0) begin
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (key_hit) begin
               if (type_ff == REQ_LOOKUP) begin
                  res_status_in = STATUS_OK;
                  res_found_in  = 1'b1;
                  res_value_in  = rd_value;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (pos_ff == '0) begin
               state_in = S_DONE;
            end else begin
               pos_in   = FILL_W'(pos_ff - 1'b1);
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (FILL_W'(pos_ff + 1'b1) < fill_ff) begin
               ent_raddr = EA_W'(base_ff + EA_W'(pos_ff) + 1'b1);
               state_in  = S_SHIFT_WR;
            end else begin
               fill_we       = 1'b1;
               fill_wdata    = FILL_W'(fill_ff - 1'b1);
               res_status_in = STATUS_OK;
               res_found_in  = 1'b1;
               res_value_in  = '0;
               state_in      = S_DONE;
            end
         end
         S_SHIFT_WR: begin
            ent_we    = 1'b1;
            ent_wdata = ent_rdata;
            pos_in    = FILL_W'(pos_ff + 1'b1);
            state_in  = S_SHIFT_RD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         type_ff  <= req_type;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      base_ff       <= base_in;
      fill_ff       <= fill_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_value_ff  <= res_value_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

FILE: rtl/bhm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bhm_ram
   import bhm_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [clog2_min1(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]              wr_data,
   input  logic [clog2_min1(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bhm_mod.sv
`timescale 1ns / 1ps
// Iterative key modulo bucket-count unit, MOD_DIG key bits per cycle.
module bhm_mod
   import bhm_pkg::*;
#(
   parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [KEY_W-1:0]                    key,
   output logic                                done,
   output logic [clog2_min1(NUM_BUCKETS)-1:0]  bucket
);

   localparam int BKT_W   = clog2_min1(NUM_BUCKETS);
   localparam int KEY_PAD = ((KEY_W + MOD_DIG - 1) / MOD_DIG) * MOD_DIG;
   localparam int STEPS   = KEY_PAD / MOD_DIG;
   localparam int CNT_W   = clog2_min1(STEPS);
   localparam logic [BKT_W:0] MOD_N = (BKT_W + 1)'(NUM_BUCKETS);
   // weight of key bit 0, 1 mod N
   localparam logic [BKT_W:0] WGT_0 = (BKT_W + 1)'(1 % NUM_BUCKETS);

   logic [KEY_PAD-1:0] sh_ff;
   logic [BKT_W:0]     rem_ff, rem_in, wgt_ff, wgt_in, t;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;

   // key mod N as the sum of the weights 2^i mod N of its set bits, LSB first;
   // sum and weight both stay below N, so one compare-subtract keeps each in range
   always_comb begin
      rem_in = rem_ff;
      wgt_in = wgt_ff;
      t      = '0;
      for (int i = 0; i < MOD_DIG; i++) begin
         t = rem_in + (sh_ff[i] ? wgt_in : '0);
         if (t >= MOD_N) begin
            t = t - MOD_N;
         end
         rem_in = t;
         t = wgt_in + wgt_in;
         if (t >= MOD_N) begin
            t = t - MOD_N;
         end
         wgt_in = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= KEY_PAD'(key);
         rem_ff <= '0;
         wgt_ff <= WGT_0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         sh_ff  <= sh_ff >> MOD_DIG;
         rem_ff <= rem_in;
         wgt_ff <= wgt_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done   = done_ff;
   assign bucket = rem_ff[BKT_W-1:0];

endmodule

FILE: rtl/bhm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bucketed hash map, bound to the top level.
module bhm_checker
   import bhm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [1:0]       rsp_status,
   input logic             rsp_found,
   input logic [VAL_W-1:0] rsp_result_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found)
         && $stable(rsp_result_value))
      else $error("result beat changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in work");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
      else $error("found flag with failing status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_MISS || rsp_status == STATUS_FULL)
         |-> !rsp_found && rsp_result_value == '0)
      else $error("failing result carries data");

endmodule

bind bucketed_hash_map bhm_checker u_bhm_checker (.*);
